@@ rtl/dpd_pkg.sv @@
// shared types, constants and helpers for the detection proposal decoder
`timescale 1ns / 1ps

package dpd_pkg;

  localparam int BOX_FIELDS = 5;
  localparam int MAX_CLASSES = 128;
  localparam int ROW_W = 15;
  localparam int CLASS_W = 7;
  localparam int POS_W = 8;
  localparam int THRESH_W = 17;
  localparam int COUNT_W = 8;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int EDGE_W = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT = 1'b1;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 17'd32768;
  localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 8'd80;

  typedef struct packed {
    logic [ROW_W-1:0]   row_number;
    logic [CLASS_W-1:0] class_index;
    logic [30:0]        objectness;
    logic [30:0]        best_score;
    logic [31:0]        center_x;
    logic [31:0]        center_y;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic               last_proposal;
  } proposal_t;

  function automatic logic signed [EDGE_W-1:0] sat13(input logic signed [17:0] v);
    logic signed [EDGE_W-1:0] r;
    if (v > 18'sd4095) begin
      r = 13'sd4095;
    end else if (v < -18'sd4096) begin
      r = -13'sd4096;
    end else begin
      r = v[EDGE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/detection_proposal_decoder.sv @@
// detection proposal decoder top level: row tracking, class argmax and proposal output
`timescale 1ns / 1ps

// Takes one tensor element per cycle, in rows of class_count + 5 elements
// (center x, center y, width, height, objectness, class scores), and issues a
// proposal for each complete row whose objectness exceeds the threshold. The
// input side accepts a transaction every cycle unless a proposal waits in both
// the stage register and the output register with out_ready low. The accepting
// edge of a row's final element registers the row fields and argmax result in
// the stage register; the output register then takes the confidence multiply
// and box corners, raising out_valid, once it is free. A partial row cut short by
// last_of_tensor is dropped. Configuration writes belong in idle periods only.
module detection_proposal_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [dpd_pkg::CFG_INDEX_W-1:0]      register_index,
  input  logic [dpd_pkg::CFG_DATA_W-1:0]       write_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [31:0]                   element_value,
  input  logic                                 last_of_tensor,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dpd_pkg::ROW_W-1:0]            row_number,
  output logic [dpd_pkg::CLASS_W-1:0]          class_index,
  output logic signed [31:0]                   confidence,
  output logic signed [dpd_pkg::EDGE_W-1:0]    left_edge,
  output logic signed [dpd_pkg::EDGE_W-1:0]    top_edge,
  output logic signed [dpd_pkg::EDGE_W-1:0]    box_width,
  output logic signed [dpd_pkg::EDGE_W-1:0]    box_height,
  output logic                                 last_proposal
);

  logic [dpd_pkg::THRESH_W-1:0] objectness_threshold;
  logic [dpd_pkg::COUNT_W-1:0]  class_count;

  logic [dpd_pkg::POS_W-1:0]    row_position;
  logic [dpd_pkg::ROW_W-1:0]    row_counter;
  logic signed [31:0]           center_x;
  logic signed [31:0]           center_y;
  logic signed [31:0]           width_held;
  logic signed [31:0]           height_held;
  logic signed [31:0]           objectness_held;
  logic signed [31:0]           best_score;
  logic [dpd_pkg::CLASS_W-1:0]  best_class;

  logic                         pipe_valid;
  dpd_pkg::proposal_t           pipe;

  logic                         out_free;
  logic                         in_take;
  logic [dpd_pkg::COUNT_W-1:0]  count_eff;
  logic [dpd_pkg::POS_W-1:0]    end_pos;
  logic                         score_phase;
  logic                         better;
  logic signed [31:0]           best_score_next;
  logic [dpd_pkg::CLASS_W-1:0]  best_class_next;
  logic [dpd_pkg::POS_W-1:0]    class_offset;
  logic                         row_end;
  logic                         emit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !pipe_valid || out_free;
  assign in_take = in_valid && in_ready;

  always_comb begin
    if (class_count == '0) begin
      count_eff = dpd_pkg::COUNT_W'(1);
    end else if (class_count > dpd_pkg::COUNT_W'(dpd_pkg::MAX_CLASSES)) begin
      count_eff = dpd_pkg::COUNT_W'(dpd_pkg::MAX_CLASSES);
    end else begin
      count_eff = class_count;
    end
    end_pos = count_eff + dpd_pkg::POS_W'(dpd_pkg::BOX_FIELDS - 1);
    score_phase = row_position >= dpd_pkg::POS_W'(dpd_pkg::BOX_FIELDS);
    class_offset = row_position - dpd_pkg::POS_W'(dpd_pkg::BOX_FIELDS);
    better = score_phase && (element_value > best_score);
    best_score_next = better ? element_value : best_score;
    best_class_next = better ? class_offset[dpd_pkg::CLASS_W-1:0] : best_class;
    row_end = row_position >= end_pos;
    emit = row_end &&
           (objectness_held > $signed({15'd0, objectness_threshold}));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      objectness_threshold <= dpd_pkg::THRESHOLD_RESET;
      class_count <= dpd_pkg::CLASS_COUNT_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        dpd_pkg::REG_THRESHOLD: begin
          objectness_threshold <= write_data[dpd_pkg::THRESH_W-1:0];
        end
        dpd_pkg::REG_CLASS_COUNT: begin
          class_count <= write_data[dpd_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // row tracking and argmax
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      row_counter <= '0;
      center_x <= '0;
      center_y <= '0;
      width_held <= '0;
      height_held <= '0;
      objectness_held <= '0;
      best_score <= '0;
      best_class <= '0;
    end else if (in_take) begin
      if (row_end || last_of_tensor) begin
        row_position <= '0;
        center_x <= '0;
        center_y <= '0;
        width_held <= '0;
        height_held <= '0;
        objectness_held <= '0;
        best_score <= '0;
        best_class <= '0;
        if (last_of_tensor) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_counter + dpd_pkg::ROW_W'(1);
        end
      end else begin
        row_position <= row_position + dpd_pkg::POS_W'(1);
        best_score <= best_score_next;
        best_class <= best_class_next;
        case (row_position)
          8'd0: center_x <= element_value;
          8'd1: center_y <= element_value;
          8'd2: width_held <= element_value;
          8'd3: height_held <= element_value;
          8'd4: objectness_held <= element_value;
          default: begin
          end
        endcase
      end
    end
  end

  // proposal stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_take) begin
      pipe_valid <= emit;
    end else if (out_free) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      pipe.row_number <= row_counter;
      pipe.class_index <= best_class_next;
      pipe.objectness <= objectness_held[30:0];
      pipe.best_score <= best_score_next[30:0];
      pipe.center_x <= center_x;
      pipe.center_y <= center_y;
      pipe.box_width <= width_held;
      pipe.box_height <= height_held;
      pipe.last_proposal <= last_of_tensor;
    end
  end

  // confidence and box corners
  logic [61:0]        product;
  logic signed [31:0] conf_sat;
  logic signed [33:0] left_diff;
  logic signed [33:0] top_diff;
  logic signed [33:0] left_adj;
  logic signed [33:0] top_adj;
  logic signed [31:0] width_adj;
  logic signed [31:0] height_adj;

  always_comb begin
    product = {31'd0, pipe.objectness} * {31'd0, pipe.best_score};
    if (|product[61:47]) begin
      conf_sat = 32'sh7fffffff;
    end else begin
      conf_sat = $signed({1'b0, product[46:16]});
    end
    left_diff = $signed({pipe.center_x[31], pipe.center_x, 1'b0}) -
                $signed({{2{pipe.box_width[31]}}, pipe.box_width});
    top_diff = $signed({pipe.center_y[31], pipe.center_y, 1'b0}) -
               $signed({{2{pipe.box_height[31]}}, pipe.box_height});
    left_adj = left_diff + (left_diff[33] ? 34'sd131071 : 34'sd0);
    top_adj = top_diff + (top_diff[33] ? 34'sd131071 : 34'sd0);
    width_adj = $signed(pipe.box_width) + (pipe.box_width[31] ? 32'sd65535 : 32'sd0);
    height_adj = $signed(pipe.box_height) + (pipe.box_height[31] ? 32'sd65535 : 32'sd0);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pipe_valid) begin
      row_number <= pipe.row_number;
      class_index <= pipe.class_index;
      confidence <= conf_sat;
      left_edge <= dpd_pkg::sat13({left_adj[33], left_adj[33:17]});
      top_edge <= dpd_pkg::sat13({top_adj[33], top_adj[33:17]});
      box_width <= dpd_pkg::sat13({{2{width_adj[31]}}, width_adj[31:16]});
      box_height <= dpd_pkg::sat13({{2{height_adj[31]}}, height_adj[31:16]});
      last_proposal <= pipe.last_proposal;
    end
  end

endmodule
